// ===== rtl/rsc_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
package rsc_pkg;

    localparam int DATA_W              = 32;
    localparam int COUNT_W             = 7;
    localparam int DEFAULT_STACK_DEPTH = 64;

    // Token codes
    typedef enum logic [2:0] {
        FN_PUSH = 3'd0,
        FN_POP  = 3'd1,
        FN_ADD  = 3'd2,
        FN_SUB  = 3'd3,
        FN_MUL  = 3'd4,
        FN_DIV  = 3'd5,
        FN_NEG  = 3'd6,
        FN_PEEK = 3'd7
    } t_func;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_DIVZ  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_B,
        S_POP_A,
        S_MUL,
        S_DIV,
        S_DIV_FIX,
        S_WB,
        S_DONE
    } t_state;

endpackage

// ===== rtl/rsc_in_if.sv =====
// Token channel: valid/ready handshake carrying one classified token.
interface rsc_in_if
    import rsc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_func                    func;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output func, output operand_value, input ready);
    modport sink   (input valid, input func, input operand_value, output ready);
endinterface

// ===== rtl/rsc_out_if.sv =====
// Result channel: valid/ready handshake carrying one result per token.
interface rsc_out_if
    import rsc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [COUNT_W-1:0]       stack_count;
    logic                     is_empty;
    t_status                  status;

    modport source (output valid, output result_value, output stack_count,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input result_value, input stack_count,
                    input is_empty, input status, output ready);
endinterface

// ===== rtl/rpn_stack_calculator.sv =====
// RPN stack calculator: stack in a synchronous RAM, sequenced read-modify-write.
//
// i_in carries one token per transfer (push, pop, peek, add, sub, mul, div, neg).
// o_out carries exactly one result per token: the popped, peeked, pushed or
// computed value, the entry count after the token, an empty flag and a status code.
// One token is processed at a time; i_in.ready is high while the sequencer idles.
// Sequencer paths to S_DONE: push directly, pop/peek/neg via S_POP_B, add/sub
//   via S_POP_B, S_POP_A and S_WB; mul adds S_MUL, div adds S_DIV and S_DIV_FIX.
// Division runs a restoring divider, one quotient bit per cycle for all 32 bits,
// which makes it the slowest token; divide by zero skips it and ends after S_POP_A.
// Stack reads go through one RAM read port with registered read data, so each
// popped operand costs its own sequencer state.
// The output register holds a finished result until o_out.ready takes it; the
// next token is accepted meanwhile, and the sequencer waits at its end only if
// the previous result is still not taken.
// Reset empties the stack and the output register; RAM contents are not cleared,
// since only entries below the stack pointer are ever read.
module rpn_stack_calculator
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsc_in_if.sink    i_in,
    rsc_out_if.source o_out
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // Stack RAM and its registered read data
    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    // Sequencer and datapath registers
    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_res, n_res;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_qneg, n_qneg;

    // Output register
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_ores, n_ores;
    logic [COUNT_W-1:0] r_ocnt, n_ocnt;
    logic              r_oempty, n_oempty;
    t_status           r_ostatus, n_ostatus;

    // Helpers
    logic                      sp_nz;
    logic [SP_W-1:0]           sp_m1;
    logic [SP_W-1:0]           sp_dec;
    logic [SP_W-1:0]           sp_dec_m1;
    logic [DATA_W-1:0]         top_val;
    logic [DATA_W-1:0]         neg_val;
    logic [DATA_W-1:0]         prod;
    logic [DATA_W:0]           rem_sh;
    logic [DATA_W:0]           rem_diff;

    assign sp_nz     = (r_sp != '0);
    assign sp_m1     = r_sp - 1'b1;
    assign sp_dec    = sp_nz ? sp_m1 : r_sp;
    assign sp_dec_m1 = sp_dec - 1'b1;
    assign top_val   = sp_nz ? r_rdata : '0;
    assign neg_val   = '0 - top_val;
    assign prod      = r_a * r_b;
    assign rem_sh    = {r_rem, r_quo[DATA_W-1]};
    assign rem_diff  = rem_sh - {1'b0, r_b};

    // RAM write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_a       <= n_a;
        r_b       <= n_b;
        r_res     <= n_res;
        r_status  <= n_status;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_qneg    <= n_qneg;
        r_ores    <= n_ores;
        r_ocnt    <= n_ocnt;
        r_oempty  <= n_oempty;
        r_ostatus <= n_ostatus;
    end

    // Next state, datapath and RAM control
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_sp      = r_sp;
        n_a       = r_a;
        n_b       = r_b;
        n_res     = r_res;
        n_status  = r_status;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_qneg    = r_qneg;
        n_ovalid  = r_ovalid;
        n_ores    = r_ores;
        n_ocnt    = r_ocnt;
        n_oempty  = r_oempty;
        n_ostatus = r_ostatus;
        mem_we    = 1'b0;
        mem_waddr = r_sp[ADDR_W-1:0];
        mem_wdata = r_res;
        mem_raddr = sp_m1[ADDR_W-1:0];
        i_in.ready = 1'b0;

        // Result taken by the receiver
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // Top entry is read every idle cycle for the next token
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_func   = i_in.func;
                    n_status = ST_OK;
                    n_res    = '0;
                    if (i_in.func == FN_PUSH) begin
                        if (r_sp < SP_W'(STACK_DEPTH)) begin
                            mem_we    = 1'b1;
                            mem_wdata = i_in.operand_value;
                            n_sp      = r_sp + 1'b1;
                            n_res     = i_in.operand_value;
                        end else begin
                            n_status = ST_FULL;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_state = S_POP_B;
                    end
                end
            end

            S_POP_B: begin
                if (!sp_nz) begin
                    n_status = ST_UNDER;
                end
                case (r_func)
                    FN_POP: begin
                        n_res   = top_val;
                        n_sp    = sp_dec;
                        n_state = S_DONE;
                    end
                    FN_PEEK: begin
                        n_res   = top_val;
                        n_state = S_DONE;
                    end
                    FN_NEG: begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_dec[ADDR_W-1:0];
                        mem_wdata = neg_val;
                        n_res     = neg_val;
                        n_sp      = sp_dec + 1'b1;
                        n_state   = S_DONE;
                    end
                    default: begin
                        // Binary operator: keep b, fetch a
                        n_b       = top_val;
                        n_sp      = sp_dec;
                        mem_raddr = sp_dec_m1[ADDR_W-1:0];
                        n_state   = S_POP_A;
                    end
                endcase
            end

            S_POP_A: begin
                n_sp = sp_dec;
                if (!sp_nz) begin
                    n_status = ST_UNDER;
                end
                case (r_func)
                    FN_ADD: begin
                        n_res   = top_val + r_b;
                        n_state = S_WB;
                    end
                    FN_SUB: begin
                        n_res   = top_val - r_b;
                        n_state = S_WB;
                    end
                    FN_MUL: begin
                        n_a     = top_val;
                        n_state = S_MUL;
                    end
                    FN_DIV: begin
                        if (r_b == '0) begin
                            // Operands consumed, nothing pushed
                            n_res    = '0;
                            n_status = ST_DIVZ;
                            n_state  = S_DONE;
                        end else begin
                            n_quo   = top_val[DATA_W-1] ? '0 - top_val : top_val;
                            n_b     = r_b[DATA_W-1] ? '0 - r_b : r_b;
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_qneg  = top_val[DATA_W-1] ^ r_b[DATA_W-1];
                            n_state = S_DIV;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_MUL: begin
                n_res   = prod;
                n_state = S_WB;
            end

            S_DIV: begin
                // Restoring step: one quotient bit per cycle
                if (!rem_diff[DATA_W]) begin
                    n_rem = rem_diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_DIV_FIX;
                end
            end

            S_DIV_FIX: begin
                n_res   = r_qneg ? '0 - r_quo : r_quo;
                n_state = S_WB;
            end

            S_WB: begin
                // Push operator result; room is guaranteed after the pops
                mem_we  = 1'b1;
                n_sp    = r_sp + 1'b1;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ores    = r_res;
                    n_ocnt    = COUNT_W'(r_sp);
                    n_oempty  = !sp_nz;
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result channel
    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_ores;
    assign o_out.stack_count  = r_ocnt;
    assign o_out.is_empty     = r_oempty;
    assign o_out.status       = r_ostatus;

endmodule
